/* rtl/rau_pkg.sv */
// ---------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ---------------------------------------------------------------------------
package rau_pkg;

    localparam int unsigned VALUE_WIDTH_DEF = 32;

    // operation codes carried by each input word
    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } t_cmd_code;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL,
        OP_ARITH,
        OP_GCD_STEP,
        OP_GCD_END,
        OP_DIV_START_N,
        OP_DIV_START_D,
        OP_DIV_STEP,
        OP_FINISH
    } t_op;

    // cross product selection for the shared multiplier
    typedef enum logic [1:0] {
        MSEL_AN_BD = 2'd0,
        MSEL_BN_AD = 2'd1,
        MSEL_AD_BD = 2'd2,
        MSEL_AN_BN = 2'd3
    } t_msel;

    typedef struct packed {
        t_op   op;
        t_msel msel;
    } t_ctl;

    typedef struct packed {
        logic invalid;
        logic gcd_done;
        logic div_done;
        logic out_busy;
    } t_stat;

endpackage

/* rtl/rau_ctrl.sv */
// ---------------------------------------------------------------------------
// rau_ctrl
// Sequencer: multiply, combine, binary gcd, two exact divisions, result.
// ---------------------------------------------------------------------------
module rau_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rau_pkg::t_stat  i_stat,
    output rau_pkg::t_ctl   o_ctl
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ARITH,
        ST_GCD,
        ST_DIVN_START,
        ST_DIVN,
        ST_DIVD,
        ST_FIN
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_mcnt, n_mcnt;

    assign o_ready = (r_state == ST_IDLE);

    // next state and datapath operation
    always_comb begin
        n_state    = r_state;
        n_mcnt     = r_mcnt;
        o_ctl.op   = rau_pkg::OP_NONE;
        o_ctl.msel = rau_pkg::t_msel'(r_mcnt);
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_ctl.op = rau_pkg::OP_LOAD;
                    n_mcnt   = 2'd0;
                    n_state  = ST_MUL;
                end
            end
            ST_MUL: begin
                o_ctl.op = rau_pkg::OP_MUL;
                n_mcnt   = r_mcnt + 2'd1;
                if (r_mcnt == 2'd3) begin
                    n_state = ST_ARITH;
                end
            end
            ST_ARITH: begin
                o_ctl.op = rau_pkg::OP_ARITH;
                n_state  = ST_GCD;
            end
            ST_GCD: begin
                priority if (i_stat.invalid) begin
                    n_state = ST_FIN;
                end else if (i_stat.gcd_done) begin
                    o_ctl.op = rau_pkg::OP_GCD_END;
                    n_state  = ST_DIVN_START;
                end else begin
                    o_ctl.op = rau_pkg::OP_GCD_STEP;
                end
            end
            ST_DIVN_START: begin
                o_ctl.op = rau_pkg::OP_DIV_START_N;
                n_state  = ST_DIVN;
            end
            ST_DIVN: begin
                if (i_stat.div_done) begin
                    o_ctl.op = rau_pkg::OP_DIV_START_D;
                    n_state  = ST_DIVD;
                end else begin
                    o_ctl.op = rau_pkg::OP_DIV_STEP;
                end
            end
            ST_DIVD: begin
                if (i_stat.div_done) begin
                    n_state = ST_FIN;
                end else begin
                    o_ctl.op = rau_pkg::OP_DIV_STEP;
                end
            end
            ST_FIN: begin
                if (!i_stat.out_busy) begin
                    o_ctl.op = rau_pkg::OP_FINISH;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mcnt  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_mcnt  <= n_mcnt;
        end
    end

endmodule

/* rtl/rau_dp.sv */
// ---------------------------------------------------------------------------
// rau_dp
// Datapath: operand magnitudes, shared multiplier, binary gcd, restoring
// divider and the output register.
// ---------------------------------------------------------------------------
module rau_dp #(
    parameter int unsigned VALUE_WIDTH = rau_pkg::VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rau_pkg::t_ctl      i_ctl,
    output rau_pkg::t_stat     o_stat,
    input  logic [1:0]         i_command,
    input  logic signed [31:0] i_a_num,
    input  logic signed [31:0] i_a_den,
    input  logic signed [31:0] i_b_num,
    input  logic signed [31:0] i_b_den,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_res_num,
    output logic [30:0]        o_res_den,
    output logic               o_invalid,
    output logic               o_overflow,
    output logic               o_is_eq,
    output logic               o_is_lt,
    output logic               o_is_le,
    output logic               o_is_gt,
    output logic               o_is_ge
);

    localparam int unsigned W  = VALUE_WIDTH;
    localparam int unsigned PW = 2 * W;
    localparam int unsigned XW = (PW > 32) ? PW : 32;
    localparam int unsigned KW = $clog2(PW);
    localparam int unsigned DW = $clog2(PW + 1);

    localparam logic [PW-1:0] HALF   = PW'(1) << (W - 1);
    localparam logic [PW-1:0] HALF_M = HALF - PW'(1);

    // operand registers
    logic [W-1:0]  r_an, r_ad, r_bn, r_bd;
    logic          r_a_neg, r_b_neg, r_a_ok, r_b_ok;
    logic [1:0]    r_cmd;
    // cross products
    logic [PW-1:0] r_p, r_q, r_dd, r_nn;
    // combined result
    logic [PW-1:0] r_rn, r_rd;
    logic          r_rneg, r_inval;
    logic          r_eq, r_lt, r_gt;
    // gcd
    logic [PW-1:0] r_x, r_y, r_g;
    logic [KW-1:0] r_k;
    // divider
    logic [PW-1:0] r_rem, r_quo, r_qn;
    logic [DW-1:0] r_dcnt;
    // output
    logic          r_out_valid;
    logic [31:0]   r_res_num;
    logic [30:0]   r_res_den;
    logic          r_o_inval, r_o_ovf, r_o_eq, r_o_lt, r_o_gt;

    // magnitudes and signs of the inputs
    logic [W-1:0] an_x, ad_x, bn_x, bd_x;
    logic [W-1:0] an_m, ad_m, bn_m, bd_m;
    assign an_x = i_a_num[W-1:0];
    assign ad_x = i_a_den[W-1:0];
    assign bn_x = i_b_num[W-1:0];
    assign bd_x = i_b_den[W-1:0];
    assign an_m = an_x[W-1] ? (W'(0) - an_x) : an_x;
    assign ad_m = ad_x[W-1] ? (W'(0) - ad_x) : ad_x;
    assign bn_m = bn_x[W-1] ? (W'(0) - bn_x) : bn_x;
    assign bd_m = bd_x[W-1] ? (W'(0) - bd_x) : bd_x;

    // shared multiplier operand selection
    logic [W-1:0]  mul_a, mul_b;
    logic [PW-1:0] mul_y;
    always_comb begin
        unique case (i_ctl.msel)
            rau_pkg::MSEL_AN_BD: begin mul_a = r_an; mul_b = r_bd; end
            rau_pkg::MSEL_BN_AD: begin mul_a = r_bn; mul_b = r_ad; end
            rau_pkg::MSEL_AD_BD: begin mul_a = r_ad; mul_b = r_bd; end
            default:             begin mul_a = r_an; mul_b = r_bn; end
        endcase
    end
    assign mul_y = PW'(mul_a) * PW'(mul_b);

    // combine cross products per command
    logic          sq;
    logic          p_ge_q;
    logic [PW-1:0] c_rn, c_rd;
    logic          c_rneg, c_eq, c_lt, c_gt, ops_ok;
    always_comb begin
        sq     = (r_cmd == rau_pkg::CMD_SUB) ? !r_b_neg : r_b_neg;
        p_ge_q = (r_p >= r_q);
        ops_ok = r_a_ok && r_b_ok;
        unique case (rau_pkg::t_cmd_code'(r_cmd))
            rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
                c_rd = r_dd;
                priority if (r_a_neg == sq) begin
                    c_rn   = r_p + r_q;
                    c_rneg = r_a_neg;
                end else if (p_ge_q) begin
                    c_rn   = r_p - r_q;
                    c_rneg = r_a_neg;
                end else begin
                    c_rn   = r_q - r_p;
                    c_rneg = sq;
                end
            end
            rau_pkg::CMD_MUL: begin
                c_rn   = r_nn;
                c_rd   = r_dd;
                c_rneg = r_a_neg != r_b_neg;
            end
            default: begin
                c_rn   = r_p;
                c_rd   = r_q;
                c_rneg = r_a_neg != r_b_neg;
            end
        endcase
        // signed compare of the cross products
        priority if (r_a_neg != r_b_neg) begin
            c_eq = 1'b0;
            c_lt = r_a_neg;
            c_gt = r_b_neg;
        end else if (r_a_neg) begin
            c_eq = (r_p == r_q);
            c_lt = !p_ge_q ? 1'b0 : (r_p != r_q);
            c_gt = !p_ge_q;
        end else begin
            c_eq = (r_p == r_q);
            c_lt = !p_ge_q;
            c_gt = p_ge_q && (r_p != r_q);
        end
        c_eq = c_eq && ops_ok;
        c_lt = c_lt && ops_ok;
        c_gt = c_gt && ops_ok;
    end

    // gcd end and divider step
    logic [PW-1:0] g_val;
    logic [PW:0]   rem_sh;
    logic          rem_ge;
    assign g_val  = PW'(((r_x == '0) ? r_y : r_x) << r_k);
    assign rem_sh = {r_rem, r_quo[PW-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_g});

    // final reduced values
    logic [PW-1:0] f_rn, f_rd;
    logic          f_neg, f_ovf;
    logic [XW-1:0] f_rn_x, f_rd_x;
    assign f_rn   = r_qn;
    assign f_rd   = r_quo;
    assign f_neg  = r_rneg && (f_rn != '0);
    assign f_ovf  = (f_rd > HALF_M) || (f_rn > (f_neg ? HALF : HALF_M));
    assign f_rn_x = XW'(f_rn);
    assign f_rd_x = XW'(f_rd);

    // status to the controller
    assign o_stat.invalid  = r_inval;
    assign o_stat.gcd_done = (r_x == '0) || (r_y == '0);
    assign o_stat.div_done = (r_dcnt == DW'(PW));
    assign o_stat.out_busy = r_out_valid && !i_ready;

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            rau_pkg::OP_LOAD: begin
                r_an    <= an_m;
                r_ad    <= ad_m;
                r_bn    <= bn_m;
                r_bd    <= bd_m;
                r_a_neg <= (an_x[W-1] != ad_x[W-1]) && (an_m != '0);
                r_b_neg <= (bn_x[W-1] != bd_x[W-1]) && (bn_m != '0);
                r_a_ok  <= (ad_m != '0);
                r_b_ok  <= (bd_m != '0);
                r_cmd   <= i_command;
            end
            rau_pkg::OP_MUL: begin
                unique case (i_ctl.msel)
                    rau_pkg::MSEL_AN_BD: r_p  <= mul_y;
                    rau_pkg::MSEL_BN_AD: r_q  <= mul_y;
                    rau_pkg::MSEL_AD_BD: r_dd <= mul_y;
                    default:             r_nn <= mul_y;
                endcase
            end
            rau_pkg::OP_ARITH: begin
                r_rn    <= c_rn;
                r_rd    <= c_rd;
                r_rneg  <= c_rneg;
                r_inval <= !ops_ok || (c_rd == '0);
                r_eq    <= c_eq;
                r_lt    <= c_lt;
                r_gt    <= c_gt;
                r_x     <= c_rn;
                r_y     <= c_rd;
                r_k     <= '0;
            end
            rau_pkg::OP_GCD_STEP: begin
                // binary gcd: pull common twos, strip lone twos, subtract odds
                priority if (!r_x[0] && !r_y[0]) begin
                    r_x <= r_x >> 1;
                    r_y <= r_y >> 1;
                    r_k <= r_k + KW'(1);
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (r_x >= r_y) begin
                    r_x <= (r_x - r_y) >> 1;
                end else begin
                    r_y <= (r_y - r_x) >> 1;
                end
            end
            rau_pkg::OP_GCD_END: begin
                r_g <= g_val;
            end
            rau_pkg::OP_DIV_START_N: begin
                r_rem  <= '0;
                r_quo  <= r_rn;
                r_dcnt <= '0;
            end
            rau_pkg::OP_DIV_START_D: begin
                r_qn   <= r_quo;
                r_rem  <= '0;
                r_quo  <= r_rd;
                r_dcnt <= '0;
            end
            rau_pkg::OP_DIV_STEP: begin
                // restoring division, one quotient bit per cycle
                r_rem  <= rem_ge ? PW'(rem_sh - {1'b0, r_g}) : PW'(rem_sh);
                r_quo  <= {r_quo[PW-2:0], rem_ge};
                r_dcnt <= r_dcnt + DW'(1);
            end
            rau_pkg::OP_FINISH: begin
                r_o_eq <= r_eq;
                r_o_lt <= r_lt;
                r_o_gt <= r_gt;
                priority if (r_inval) begin
                    r_res_num <= '0;
                    r_res_den <= '0;
                    r_o_inval <= 1'b1;
                    r_o_ovf   <= 1'b0;
                end else if (f_ovf) begin
                    r_res_num <= '0;
                    r_res_den <= '0;
                    r_o_inval <= 1'b0;
                    r_o_ovf   <= 1'b1;
                end else begin
                    r_res_num <= f_neg ? (32'd0 - f_rn_x[31:0]) : f_rn_x[31:0];
                    r_res_den <= f_rd_x[30:0];
                    r_o_inval <= 1'b0;
                    r_o_ovf   <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.op == rau_pkg::OP_FINISH) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_res_num  = r_res_num;
    assign o_res_den  = r_res_den;
    assign o_invalid  = r_o_inval;
    assign o_overflow = r_o_ovf;
    assign o_is_eq    = r_o_eq;
    assign o_is_lt    = r_o_lt;
    assign o_is_le    = r_o_lt || r_o_eq;
    assign o_is_gt    = r_o_gt;
    assign o_is_ge    = r_o_gt || r_o_eq;

endmodule

/* rtl/rational_arithmetic_unit.sv */
// Sequence: load, multiply, combine, binary gcd steps, gcd end, divide start, numerator
// divide, denominator divide, finish; an invalid word goes from the gcd state to finish.
// The binary gcd loop and the one-bit-per-cycle restoring divider, run twice, take
// most of the time. One word is worked on at a time. A new word is taken while the
// last result still waits. Synchronous active-low reset returns the sequencer
// to idle and empties the output register.
// ---------------------------------------------------------------------------
// rational_arithmetic_unit
// Add, subtract, multiply or divide two fractions, reduced by their gcd, plus
// the comparison flags between the operands.
// ---------------------------------------------------------------------------
module rational_arithmetic_unit #(
    parameter int unsigned VALUE_WIDTH = rau_pkg::VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_command,
    input  logic signed [31:0] i_a_num,
    input  logic signed [31:0] i_a_den,
    input  logic signed [31:0] i_b_num,
    input  logic signed [31:0] i_b_den,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_res_num,
    output logic [30:0]        o_res_den,
    output logic               o_invalid,
    output logic               o_overflow,
    output logic               o_is_eq,
    output logic               o_is_lt,
    output logic               o_is_le,
    output logic               o_is_gt,
    output logic               o_is_ge
);

    rau_pkg::t_ctl  ctl;
    rau_pkg::t_stat stat;

    // sequencer
    rau_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    // arithmetic datapath
    rau_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .o_stat     (stat),
        .i_command  (i_command),
        .i_a_num    (i_a_num),
        .i_a_den    (i_a_den),
        .i_b_num    (i_b_num),
        .i_b_den    (i_b_den),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res_num  (o_res_num),
        .o_res_den  (o_res_den),
        .o_invalid  (o_invalid),
        .o_overflow (o_overflow),
        .o_is_eq    (o_is_eq),
        .o_is_lt    (o_is_lt),
        .o_is_le    (o_is_le),
        .o_is_gt    (o_is_gt),
        .o_is_ge    (o_is_ge)
    );

endmodule

/* rtl/rau_checker.sv */
// ---------------------------------------------------------------------------
// rau_checker
// Port-level checks of the rational arithmetic unit.
// ---------------------------------------------------------------------------
module rau_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_res_num,
    input logic [30:0]        o_res_den,
    input logic               o_invalid,
    input logic               o_overflow,
    input logic               o_is_eq,
    input logic               o_is_lt,
    input logic               o_is_le,
    input logic               o_is_gt,
    input logic               o_is_ge
);

    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res_num) && $stable(o_res_den))
        else $error("result word changed while stalled");

    // invalid and overflow never together, both zero the fraction
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_invalid || o_overflow) |->
            !(o_invalid && o_overflow) && o_res_num == 0 && o_res_den == 0)
        else $error("bad invalid/overflow word");

    // a good result has a positive denominator
    a_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_invalid && !o_overflow |-> o_res_den != 0)
        else $error("zero denominator on good result");

    // comparison flags agree with each other
    a_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones({o_is_eq, o_is_lt, o_is_gt}) <= 1 &&
            o_is_le == (o_is_lt || o_is_eq) && o_is_ge == (o_is_gt || o_is_eq))
        else $error("inconsistent comparison flags");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);
